>>> rtl/core/irdt_pkg.sv
// Shared types, constants and calibration ROM for the IR distance table interpolator.
`default_nettype none

package irdt_pkg;

    // Field widths of the item channels.
    localparam int READING_W  = 8;
    localparam int SEL_W      = 3;
    localparam int DIST_W     = 8;
    localparam int STATUS_W   = 2;

    // Default configuration handed to the top level.
    localparam int SENSOR_COUNT_DEF = 7;
    localparam int TABLE_DEPTH_DEF  = 64;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEAR    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAR     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    // Distance codes for the out-of-range answers.
    localparam logic [DIST_W-1:0] DIST_MIN = 8'h00;
    localparam logic [DIST_W-1:0] DIST_MAX = 8'hFF;

    // Calibration ROM contents.
    localparam int ROM_TABLES  = 7;
    localparam int ROM_MAX_LEN = 37;

    localparam logic [7:0] ROM_LEN [ROM_TABLES] = '{8'd37, 8'd37, 8'd37, 8'd37,
                                                    8'd27, 8'd27, 8'd37};

    localparam logic [7:0] LONG_DIST [ROM_MAX_LEN] = '{
        8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
        8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34,
        8'd35, 8'd37, 8'd40, 8'd45, 8'd50, 8'd55, 8'd60, 8'd65, 8'd70, 8'd75,
        8'd80, 8'd90, 8'd100, 8'd110, 8'd120, 8'd130, 8'd140};

    localparam logic [7:0] SHORT_DIST [ROM_MAX_LEN] = '{
        8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
        8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
        8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

    localparam logic [7:0] ROM_READ [ROM_TABLES][ROM_MAX_LEN] = '{
        '{8'd136, 8'd134, 8'd132, 8'd130, 8'd128, 8'd125, 8'd122, 8'd120, 8'd117,
          8'd115, 8'd112, 8'd109, 8'd106, 8'd103, 8'd101, 8'd98, 8'd96, 8'd94,
          8'd91, 8'd89, 8'd87, 8'd83, 8'd77, 8'd69, 8'd61, 8'd56, 8'd52, 8'd48,
          8'd44, 8'd41, 8'd40, 8'd36, 8'd32, 8'd29, 8'd27, 8'd24, 8'd22},
        '{8'd136, 8'd135, 8'd132, 8'd130, 8'd128, 8'd126, 8'd123, 8'd120, 8'd118,
          8'd115, 8'd112, 8'd109, 8'd105, 8'd102, 8'd100, 8'd97, 8'd95, 8'd92,
          8'd89, 8'd87, 8'd84, 8'd80, 8'd74, 8'd66, 8'd59, 8'd53, 8'd49, 8'd45,
          8'd42, 8'd40, 8'd37, 8'd33, 8'd29, 8'd26, 8'd24, 8'd22, 8'd20},
        '{8'd141, 8'd138, 8'd135, 8'd133, 8'd130, 8'd127, 8'd125, 8'd121, 8'd118,
          8'd115, 8'd111, 8'd108, 8'd105, 8'd102, 8'd99, 8'd95, 8'd93, 8'd90,
          8'd88, 8'd85, 8'd83, 8'd78, 8'd73, 8'd65, 8'd58, 8'd53, 8'd49, 8'd45,
          8'd42, 8'd39, 8'd36, 8'd32, 8'd28, 8'd26, 8'd24, 8'd22, 8'd20},
        '{8'd139, 8'd138, 8'd136, 8'd135, 8'd136, 8'd130, 8'd126, 8'd122, 8'd120,
          8'd117, 8'd113, 8'd110, 8'd107, 8'd104, 8'd102, 8'd99, 8'd96, 8'd94,
          8'd92, 8'd89, 8'd87, 8'd83, 8'd76, 8'd69, 8'd58, 8'd56, 8'd47, 8'd43,
          8'd42, 8'd38, 8'd38, 8'd33, 8'd31, 8'd28, 8'd25, 8'd23, 8'd21},
        '{8'd126, 8'd106, 8'd92, 8'd80, 8'd71, 8'd64, 8'd58, 8'd53, 8'd48,
          8'd46, 8'd42, 8'd39, 8'd37, 8'd35, 8'd33, 8'd31, 8'd29, 8'd27,
          8'd26, 8'd25, 8'd24, 8'd23, 8'd22, 8'd21, 8'd20, 8'd19, 8'd18, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd133, 8'd112, 8'd99, 8'd88, 8'd77, 8'd69, 8'd63, 8'd57, 8'd53,
          8'd49, 8'd46, 8'd43, 8'd39, 8'd37, 8'd34, 8'd32, 8'd30, 8'd29,
          8'd27, 8'd26, 8'd24, 8'd23, 8'd22, 8'd21, 8'd20, 8'd19, 8'd18, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd133, 8'd131, 8'd128, 8'd128, 8'd125, 8'd122, 8'd121, 8'd118, 8'd114,
          8'd113, 8'd110, 8'd106, 8'd104, 8'd101, 8'd98, 8'd96, 8'd94, 8'd91,
          8'd89, 8'd86, 8'd84, 8'd80, 8'd74, 8'd66, 8'd59, 8'd54, 8'd49, 8'd45,
          8'd42, 8'd40, 8'd37, 8'd33, 8'd29, 8'd27, 8'd23, 8'd21, 8'd19}};

    // Number of ROM entries a sensor slot holds; slots without a table hold none.
    function automatic logic [7:0] rom_table_len(input logic [SEL_W-1:0] sel);
        logic [7:0] len;
        len = 8'd0;
        if (32'(sel) < ROM_TABLES)
        begin
            len = ROM_LEN[sel];
        end
        return len;
    endfunction

    // One calibration entry: distance in the high byte, reading in the low byte.
    function automatic logic [15:0] rom_entry(input logic [SEL_W-1:0] sel,
                                              input logic [7:0] idx);
        logic [15:0] entry;
        logic [7:0]  ent_dist;
        entry = 16'd0;
        if (idx < rom_table_len(sel))
        begin
            if (sel == 3'd4 || sel == 3'd5)
            begin
                ent_dist = SHORT_DIST[idx[5:0]];
            end
            else
            begin
                ent_dist = LONG_DIST[idx[5:0]];
            end
            entry = {ent_dist, ROM_READ[sel][idx[5:0]]};
        end
        return entry;
    endfunction

    // Datapath operations selected by the microcode.
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CHECK,
        OP_SCAN,
        OP_MUL,
        OP_DIV,
        OP_FIN,
        OP_EMIT,
        OP_NONE
    } op_t;

    // Conditions reported by the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic bad_sel;
        logic scan_direct;
        logic scan_miss;
        logic div_more;
        logic out_free;
    } irdt_cond_t;

endpackage

`default_nettype wire

>>> rtl/core/irdt_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
`default_nettype none

module irdt_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire irdt_pkg::irdt_cond_t cond,
    output irdt_pkg::op_t            op
);
    import irdt_pkg::*;

    // Condition selector codes of a control word.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_FIRE,
        C_BAD_SEL,
        C_SCAN_DIRECT,
        C_SCAN_MISS,
        C_DIV_MORE,
        C_OUT_FREE
    } csel_t;

    // Program addresses.
    localparam logic [2:0] PC_IDLE  = 3'd0;
    localparam logic [2:0] PC_CHECK = 3'd1;
    localparam logic [2:0] PC_SCAN  = 3'd2;
    localparam logic [2:0] PC_MUL   = 3'd3;
    localparam logic [2:0] PC_DIV   = 3'd4;
    localparam logic [2:0] PC_FIN   = 3'd5;
    localparam logic [2:0] PC_EMIT  = 3'd6;

    // Control word: operation, jump condition and target, hold condition.
    typedef struct packed {
        op_t        op;
        csel_t      jump_cond;
        logic [2:0] jump_tgt;
        csel_t      hold_cond;
    } uword_t;

    logic [2:0] pc_reg;
    logic [2:0] pc_next;
    uword_t     word;
    logic       jump_hit;
    logic       hold_hit;

    // Program ROM.
    function automatic uword_t program_word(input logic [2:0] pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:  w = '{OP_LOAD,  C_IN_FIRE,     PC_CHECK, C_ALWAYS};
            PC_CHECK: w = '{OP_CHECK, C_BAD_SEL,     PC_EMIT,  C_NEVER};
            PC_SCAN:  w = '{OP_SCAN,  C_SCAN_DIRECT, PC_EMIT,  C_SCAN_MISS};
            PC_MUL:   w = '{OP_MUL,   C_NEVER,       PC_IDLE,  C_NEVER};
            PC_DIV:   w = '{OP_DIV,   C_NEVER,       PC_IDLE,  C_DIV_MORE};
            PC_FIN:   w = '{OP_FIN,   C_NEVER,       PC_IDLE,  C_NEVER};
            PC_EMIT:  w = '{OP_EMIT,  C_OUT_FREE,    PC_IDLE,  C_ALWAYS};
            default:  w = '{OP_NONE,  C_ALWAYS,      PC_IDLE,  C_NEVER};
        endcase
        return w;
    endfunction

    // Evaluate one condition selector.
    function automatic logic eval_cond(input csel_t sel, input irdt_cond_t c);
        logic hit;
        unique case (sel)
            C_NEVER:       hit = 1'b0;
            C_ALWAYS:      hit = 1'b1;
            C_IN_FIRE:     hit = c.in_fire;
            C_BAD_SEL:     hit = c.bad_sel;
            C_SCAN_DIRECT: hit = c.scan_direct;
            C_SCAN_MISS:   hit = c.scan_miss;
            C_DIV_MORE:    hit = c.div_more;
            C_OUT_FREE:    hit = c.out_free;
            default:       hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Next step: jump, hold, or fall through.
    always_comb
    begin
        word     = program_word(pc_reg);
        jump_hit = eval_cond(word.jump_cond, cond);
        hold_hit = eval_cond(word.hold_cond, cond);
        priority if (jump_hit)
        begin
            pc_next = word.jump_tgt;
        end
        else if (hold_hit)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
    end

    assign op = word.op;

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ir_distance_table_interpolator.sv
// Top level of the IR distance table interpolator: datapath and output register.
//
// Input channel: in_valid/in_ready carries one beat of reading and sensor_select.
// Output channel: out_valid/out_ready carries one beat of distance and status.
// Each input beat produces exactly one output beat.
// Items are handled one at a time under a microcoded sequencer. After input
// acceptance, an unknown or empty sensor goes from the check step straight to
// the emit step, which loads the result into the output register. Otherwise
// the search steps through the table, one ROM entry per cycle, until it finds
// the answer or runs past the end; when the reading falls between two entries,
// a multiply step, a 16-step restoring divide and a final step come before the
// emit step.
// in_ready is high only while the sequencer waits at its idle step. A new
// beat is accepted while a finished result still waits in the output register.
// A stalled receiver holds the sequencer at its emit step until the register
// frees up. Reset empties the output register and returns the sequencer to
// idle; the calibration tables are constant ROM and need no initialization.
`default_nettype none

module ir_distance_table_interpolator #(
    parameter int SENSOR_COUNT = irdt_pkg::SENSOR_COUNT_DEF,
    parameter int TABLE_DEPTH  = irdt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [irdt_pkg::READING_W-1:0] reading,
    input  wire logic [irdt_pkg::SEL_W-1:0]     sensor_select,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [irdt_pkg::DIST_W-1:0]         distance,
    output logic [irdt_pkg::STATUS_W-1:0]       status
);
    import irdt_pkg::*;

    // Index counts up to one past the table length.
    localparam int IDX_W = $clog2(TABLE_DEPTH + 2);

    op_t                   op;
    irdt_cond_t            cond;
    logic                  in_fire;

    logic [READING_W-1:0]  raw_reg,  raw_next;
    logic [SEL_W-1:0]      sel_reg,  sel_next;
    logic [IDX_W-1:0]      idx_reg,  idx_next;
    logic [IDX_W-1:0]      hit_reg;
    logic [IDX_W-1:0]      len_reg,  len_next;
    logic [15:0]           rom_q_reg;
    logic [7:0]            pv_reg,   pv_next;
    logic [7:0]            pd_reg,   pd_next;
    logic [7:0]            nv_reg,   nv_next;
    logic [7:0]            nd_reg,   nd_next;
    logic                  neg_reg,  neg_next;
    logic [7:0]            den_reg,  den_next;
    logic [7:0]            rem_reg,  rem_next;
    logic [15:0]           quo_reg,  quo_next;
    logic [3:0]            cnt_reg,  cnt_next;
    logic [DIST_W-1:0]     res_dist_reg, res_dist_next;
    logic [STATUS_W-1:0]   res_stat_reg, res_stat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]     distance_reg, distance_next;
    logic [STATUS_W-1:0]   status_reg,   status_next;

    logic                  unknown_sel;
    logic [7:0]            rom_len;
    logic [7:0]            lim_len;
    logic [IDX_W-1:0]      len_calc;
    logic [7:0]            ent_v;
    logic [7:0]            ent_d;
    logic                  out_of_range;
    logic                  scan_near;
    logic                  scan_found;
    logic                  scan_exact;
    logic [7:0]            mag;
    logic [7:0]            fac;
    logic [8:0]            div_trial;
    logic [8:0]            div_diff;
    logic                  div_ge;
    logic [16:0]           adj;
    logic signed [18:0]    sum;
    logic                  out_free;

    // Sequencer.
    irdt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .op    (op)
    );

    assign in_ready = (op == OP_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Sensor selection and table length.
    always_comb
    begin
        unknown_sel = ({1'b0, sel_reg} >= 4'(SENSOR_COUNT));
        rom_len     = rom_table_len(sel_reg);
        lim_len     = (rom_len > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH) : rom_len;
        len_calc    = IDX_W'(lim_len);
    end

    // Classification of the ROM entry under test.
    always_comb
    begin
        ent_v        = rom_q_reg[7:0];
        ent_d        = rom_q_reg[15:8];
        out_of_range = (hit_reg >= len_reg);
        scan_found   = (ent_v <= raw_reg);
        scan_near    = (hit_reg == '0) && (raw_reg > ent_v);
        scan_exact   = scan_found && ((ent_v == raw_reg) || (hit_reg == '0));
    end

    // Condition flags for the sequencer.
    always_comb
    begin
        cond.in_fire     = in_fire;
        cond.bad_sel     = unknown_sel || (len_calc == '0);
        cond.scan_direct = out_of_range || scan_near || scan_exact;
        cond.scan_miss   = !out_of_range && !scan_found;
        cond.div_more    = (cnt_reg != 4'hF);
        cond.out_free    = out_free;
    end

    // Arithmetic helpers for the multiply, divide and final steps.
    always_comb
    begin
        mag       = (nd_reg < pd_reg) ? (pd_reg - nd_reg) : (nd_reg - pd_reg);
        fac       = pv_reg - raw_reg;
        div_trial = {rem_reg, quo_reg[15]};
        div_diff  = div_trial - {1'b0, den_reg};
        div_ge    = (div_trial >= {1'b0, den_reg});
        adj       = {1'b0, quo_reg} + 17'(neg_reg && (rem_reg != 8'd0));
        sum       = neg_reg ? ($signed({11'd0, pd_reg}) - $signed({2'd0, adj}))
                            : ($signed({11'd0, pd_reg}) + $signed({2'd0, adj}));
    end

    // Datapath operations.
    always_comb
    begin
        raw_next       = raw_reg;
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        pv_next        = pv_reg;
        pd_next        = pd_reg;
        nv_next        = nv_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_dist_next  = res_dist_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        distance_next  = distance_reg;
        status_next    = status_reg;

        unique case (op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    raw_next = reading;
                    sel_next = sensor_select;
                    idx_next = '0;
                end
            end
            OP_CHECK:
            begin
                len_next = len_calc;
                idx_next = idx_reg + 1'b1;
                if (unknown_sel)
                begin
                    res_dist_next = DIST_MIN;
                    res_stat_next = ST_UNKNOWN;
                end
                else
                begin
                    res_dist_next = DIST_MAX;
                    res_stat_next = ST_FAR;
                end
            end
            OP_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                priority if (out_of_range)
                begin
                    res_dist_next = DIST_MAX;
                    res_stat_next = ST_FAR;
                end
                else if (scan_near)
                begin
                    res_dist_next = DIST_MIN;
                    res_stat_next = ST_NEAR;
                end
                else if (scan_exact)
                begin
                    res_dist_next = ent_d;
                    res_stat_next = ST_OK;
                end
                else if (scan_found)
                begin
                    nv_next = ent_v;
                    nd_next = ent_d;
                end
                else
                begin
                    pv_next = ent_v;
                    pd_next = ent_d;
                end
            end
            OP_MUL:
            begin
                neg_next = (nd_reg < pd_reg);
                quo_next = {8'd0, mag} * {8'd0, fac};
                den_next = pv_reg - nv_reg;
                rem_next = 8'd0;
                cnt_next = 4'd0;
            end
            OP_DIV:
            begin
                rem_next = div_ge ? div_diff[7:0] : div_trial[7:0];
                quo_next = {quo_reg[14:0], div_ge};
                cnt_next = cnt_reg + 4'd1;
            end
            OP_FIN:
            begin
                res_stat_next = ST_OK;
                priority if (sum < 0)
                begin
                    res_dist_next = DIST_MIN;
                end
                else if (sum > 19'sd255)
                begin
                    res_dist_next = DIST_MAX;
                end
                else
                begin
                    res_dist_next = sum[7:0];
                end
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = res_dist_reg;
                    status_next    = res_stat_reg;
                end
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers and the registered ROM read.
    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        sel_reg      <= sel_next;
        idx_reg      <= idx_next;
        hit_reg      <= idx_reg;
        rom_q_reg    <= rom_entry(sel_reg, 8'(idx_reg));
        len_reg      <= len_next;
        pv_reg       <= pv_next;
        pd_reg       <= pd_next;
        nv_reg       <= nv_next;
        nd_reg       <= nd_next;
        neg_reg      <= neg_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        res_dist_reg <= res_dist_next;
        res_stat_reg <= res_stat_next;
        distance_reg <= distance_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> tb/irdt_result_checker.sv
// Channel monitor, distance predictor and result comparison for the IR distance interpolator.
`timescale 1ns / 1ps

module irdt_result_checker #(
    parameter int SENSOR_COUNT = irdt_pkg::SENSOR_COUNT_DEF,
    parameter int TABLE_DEPTH  = irdt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [irdt_pkg::READING_W-1:0] reading,
    input  logic [irdt_pkg::SEL_W-1:0]     sensor_select,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [irdt_pkg::DIST_W-1:0]    distance,
    input  logic [irdt_pkg::STATUS_W-1:0]  status,
    output int                             fail_count,
    output int                             pending,
    output int                             checked
);
    import irdt_pkg::*;

    // Sensor slots whose tables use the short-range distance column.
    localparam int SHORT_SLOT_A = 4;
    localparam int SHORT_SLOT_B = 5;

    typedef struct packed {
        logic [DIST_W-1:0]   dist_val;
        logic [STATUS_W-1:0] stat;
    } range_result_t;

    // Calibration pairs: distance in the high byte, reading in the low byte.
    logic [15:0]   cal_store [SENSOR_COUNT*TABLE_DEPTH];
    int            table_len [SENSOR_COUNT];
    range_result_t expected_q [$];
    range_result_t oldest;
    int            n_fail;
    int            n_checked;
    int            n_pending;

    assign fail_count = n_fail;
    assign pending    = n_pending;
    assign checked    = n_checked;

    // Load the calibration tables the same way the block's ROM lays them out.
    initial
    begin
        int         len;
        logic [7:0] d;
        n_fail    = 0;
        n_checked = 0;
        n_pending = 0;
        for (int s = 0; s < SENSOR_COUNT; s++)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                cal_store[s*TABLE_DEPTH + i] = 16'd0;
            end
            len = (s < ROM_TABLES) ? int'(ROM_LEN[s]) : 0;
            if (len > TABLE_DEPTH)
            begin
                len = TABLE_DEPTH;
            end
            table_len[s] = len;
            for (int i = 0; i < len; i++)
            begin
                d = (s == SHORT_SLOT_A || s == SHORT_SLOT_B) ? SHORT_DIST[i] : LONG_DIST[i];
                cal_store[s*TABLE_DEPTH + i] = {d, ROM_READ[s][i]};
            end
        end
    end

    // Expected distance and status for one reading on one sensor.
    function automatic range_result_t lookup_distance(input logic [READING_W-1:0] raw,
                                                      input logic [SEL_W-1:0] sel);
        range_result_t res;
        int len, base, i, pv, pd, nv, nd, den, num, q, sum;
        res.dist_val = DIST_MIN;
        res.stat     = ST_UNKNOWN;
        if (int'(sel) >= SENSOR_COUNT)
        begin
            return res;
        end
        len = table_len[sel];
        if (len > TABLE_DEPTH)
        begin
            len = TABLE_DEPTH;
        end
        // A slot without a table reads as too far.
        if (len == 0)
        begin
            res.dist_val = DIST_MAX;
            res.stat     = ST_FAR;
            return res;
        end
        base = int'(sel) * TABLE_DEPTH;
        if (int'(raw) > int'(cal_store[base][7:0]))
        begin
            res.dist_val = DIST_MIN;
            res.stat     = ST_NEAR;
            return res;
        end
        // First entry whose reading is not above the input.
        i = 0;
        while (i < len && int'(cal_store[base + i][7:0]) > int'(raw))
        begin
            i++;
        end
        if (i >= len)
        begin
            res.dist_val = DIST_MAX;
            res.stat     = ST_FAR;
            return res;
        end
        nv = int'(cal_store[base + i][7:0]);
        nd = int'(cal_store[base + i][15:8]);
        res.stat = ST_OK;
        if (nv == int'(raw) || i == 0)
        begin
            res.dist_val = nd[7:0];
            return res;
        end
        // Interpolate between the neighbors, flooring toward minus infinity.
        pv  = int'(cal_store[base + i - 1][7:0]);
        pd  = int'(cal_store[base + i - 1][15:8]);
        den = pv - nv;
        num = (nd - pd) * (pv - int'(raw));
        if (num >= 0)
        begin
            q = num / den;
        end
        else
        begin
            q = -((-num + den - 1) / den);
        end
        sum = pd + q;
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > 255)
        begin
            sum = 255;
        end
        res.dist_val = sum[7:0];
        return res;
    endfunction

    // Compare each result beat with the oldest prediction, then record new input beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            n_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected: distance %0d status %0d",
                           distance, status);
                    n_fail++;
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    n_checked++;
                    if (distance !== oldest.dist_val)
                    begin
                        $error("distance expected %0d actual %0d", oldest.dist_val, distance);
                        n_fail++;
                    end
                    if (status !== oldest.stat)
                    begin
                        $error("status expected %0d actual %0d", oldest.stat, status);
                        n_fail++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(lookup_distance(reading, sensor_select));
            end
            n_pending = expected_q.size();
        end
    end

endmodule

>>> tb/tb_ir_distance_table_interpolator.sv
// Stimulus, flow control and verdict for the IR distance table interpolator.
`timescale 1ns / 1ps

module tb_ir_distance_table_interpolator;
    import irdt_pkg::*;

    localparam int SENSOR_COUNT   = SENSOR_COUNT_DEF;
    localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
    localparam int PHASE_ITEMS    = 300;
    localparam int BURST_ITEMS    = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_DIRECTED     = 25;

    // Directed beats: {reading, sensor_select}.
    localparam logic [10:0] DIRECTED [N_DIRECTED] = '{
        {8'd255, 3'd0}, {8'd136, 3'd0}, {8'd135, 3'd0}, {8'd0, 3'd0},
        {8'd22, 3'd0},  {8'd21, 3'd0},  {8'd0, 3'd7},   {8'd255, 3'd7},
        {8'd100, 3'd3}, {8'd133, 3'd3}, {8'd136, 3'd3}, {8'd135, 3'd3},
        {8'd141, 3'd2}, {8'd142, 3'd2}, {8'd127, 3'd4}, {8'd126, 3'd4},
        {8'd18, 3'd4},  {8'd17, 3'd4},  {8'd60, 3'd5},  {8'd128, 3'd6},
        {8'd19, 3'd6},  {8'd18, 3'd6},  {8'd50, 3'd1},  {8'd85, 3'd2},
        {8'd200, 3'd5}};

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [READING_W-1:0] reading;
    logic [SEL_W-1:0]     sensor_select;
    logic                 out_valid;
    logic                 out_ready;
    logic [DIST_W-1:0]    distance;
    logic [STATUS_W-1:0]  status;

    int fail_count;
    int pending;
    int checked;
    int idle_pct;
    int stall_pct;
    int hold_asked;
    int hold_served;
    int n_sent;
    int quiet_cycles;

    ir_distance_table_interpolator #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .reading       (reading),
        .sensor_select (sensor_select),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .distance      (distance),
        .status        (status)
    );

    irdt_result_checker #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .reading       (reading),
        .sensor_select (sensor_select),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .distance      (distance),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a beat", quiet_cycles);
            $display("FAIL ir_distance_table_interpolator");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_served = hold_served + 1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one beat, starting at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input logic [READING_W-1:0] r, input logic [SEL_W-1:0] s);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        reading       <= r;
        sensor_select <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        n_sent++;
        @(negedge clk);
    endtask

    // Mostly valid sensors with readings inside the tables, some noise.
    task automatic send_random_beat();
        logic [READING_W-1:0] r;
        logic [SEL_W-1:0]     s;
        int                   kind;
        int                   len;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            s = SEL_W'(SENSOR_COUNT);
            r = READING_W'($urandom);
        end
        else if (kind < 18)
        begin
            s = SEL_W'($urandom);
            r = READING_W'($urandom);
        end
        else
        begin
            s   = SEL_W'($urandom_range(0, ROM_TABLES - 1));
            len = int'(ROM_LEN[s]);
            if (kind < 45)
            begin
                r = ROM_READ[s][$urandom_range(0, len - 1)];
            end
            else
            begin
                r = READING_W'($urandom_range(12, 146));
            end
        end
        send_beat(r, s);
    endtask

    // Withdraw the input and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            send_random_beat();
        end
        drain_results();
    endtask

    // Main stimulus.
    initial
    begin
        in_valid      = 1'b0;
        reading       = '0;
        sensor_select = '0;
        rst_n         = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_asked    = 0;
        hold_served   = 0;
        n_sent        = 0;
        quiet_cycles  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Table edges, exact matches, the non-monotone stretch and unknown sensors.
        for (int k = 0; k < N_DIRECTED; k++)
        begin
            send_beat(DIRECTED[k][10:3], DIRECTED[k][2:0]);
        end
        drain_results();

        run_phase(0, 0);
        run_phase(86, 0);
        run_phase(0, 86);
        run_phase(25, 25);

        // Hold the output off while the sender keeps offering, so the input stalls.
        idle_pct   = 0;
        stall_pct  = 0;
        hold_asked = hold_asked + 1;
        for (int k = 0; k < BURST_ITEMS; k++)
        begin
            send_random_beat();
        end
        drain_results();

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d beats: directed edges, then unthrottled, sender-idle,", n_sent);
        $display("receiver-stall, mixed phases and a %0d-cycle output hold; %0d results compared.",
                 HOLD_CYCLES, checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS ir_distance_table_interpolator");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("FAIL ir_distance_table_interpolator");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/irdt_pkg.sv
rtl/core/irdt_seq.sv
rtl/core/ir_distance_table_interpolator.sv
tb/irdt_result_checker.sv
tb/tb_ir_distance_table_interpolator.sv
